@@ rtl/core/c2c_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2c_pkg
// Shared types and constants of the cartesian to cylindrical converter: field
// widths, configuration register indexes, the per-item flag group and the
// Q60 arctangent table of the vectoring CORDIC.
// ----------------------------------------------------------------------------
package c2c_pkg;

    localparam int ITERS     = 60;
    localparam int ANGLE_W   = 23;
    localparam int RADIUS_W  = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 8'd1;

    typedef struct packed {
        logic dx_neg;
        logic dz_neg;
        logic ux_zero;
        logic uz_zero;
    } c2c_flags_t;

    // Division by the odd number 2k+1, for the series terms below.
    function automatic longint unsigned c2c_div_odd(input longint unsigned v, input int k);
        case (k)
            0:       return v;
            1:       return v / 3;
            2:       return v / 5;
            3:       return v / 7;
            4:       return v / 9;
            5:       return v / 11;
            6:       return v / 13;
            7:       return v / 15;
            8:       return v / 17;
            9:       return v / 19;
            10:      return v / 21;
            11:      return v / 23;
            12:      return v / 25;
            13:      return v / 27;
            14:      return v / 29;
            15:      return v / 31;
            16:      return v / 33;
            17:      return v / 35;
            18:      return v / 37;
            19:      return v / 39;
            20:      return v / 41;
            21:      return v / 43;
            22:      return v / 45;
            23:      return v / 47;
            24:      return v / 49;
            25:      return v / 51;
            26:      return v / 53;
            27:      return v / 55;
            28:      return v / 57;
            29:      return v / 59;
            default: return 64'd0;
        endcase
    endfunction

    // atan(2^-idx) in Q60. Entry zero is pi/4 by Machin's formula, the
    // others come from the Taylor series of atan evaluated term by term.
    function automatic longint c2c_atan_q60(input int idx);
        longint            s;
        longint            s5;
        longint            s239;
        longint unsigned   t;
        int                k;
        if (idx == 0) begin
            s5 = 0;
            t  = (64'd1 << 60) / 5;
            k  = 0;
            while (t != 64'd0) begin
                if (k[0]) s5 = s5 - longint'(c2c_div_odd(t, k));
                else      s5 = s5 + longint'(c2c_div_odd(t, k));
                t = t / 25;
                k = k + 1;
            end
            s239 = 0;
            t    = (64'd1 << 60) / 239;
            k    = 0;
            while (t != 64'd0) begin
                if (k[0]) s239 = s239 - longint'(c2c_div_odd(t, k));
                else      s239 = s239 + longint'(c2c_div_odd(t, k));
                t = t / 57121;
                k = k + 1;
            end
            return 4 * s5 - s239;
        end
        s = 0;
        k = 0;
        while (idx * (2 * k + 1) <= 60) begin
            t = 64'd1 << (60 - idx * (2 * k + 1));
            if (k[0]) s = s - longint'(c2c_div_odd(t, k));
            else      s = s + longint'(c2c_div_odd(t, k));
            k = k + 1;
        end
        return s;
    endfunction

    localparam longint ATAN_PI4    = c2c_atan_q60(0);
    localparam longint HALF_PI_Q60 = 2 * ATAN_PI4;
    localparam longint PI_Q60      = 4 * ATAN_PI4;

endpackage

@@ rtl/core/c2c_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2c_delay
// Enabled shift line that keeps side data level with the longest pipeline
// path.
// ----------------------------------------------------------------------------
module c2c_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

@@ rtl/core/c2c_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2c_isqrt
// Sum of squares from split partial products, then a pipelined restoring
// square root producing one root bit per stage.
// ----------------------------------------------------------------------------
module c2c_isqrt import c2c_pkg::*; #(
    parameter int COORD_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [COORD_WIDTH-1:0] ux,
    input  logic [COORD_WIDTH-1:0] uz,
    output logic [COORD_WIDTH:0]   root
);

    localparam int HW    = (COORD_WIDTH + 1) / 2;
    localparam int RB    = COORD_WIDTH + 1;
    localparam int RW    = 2 * RB;
    localparam int REM_W = RB + 2;

    logic [2*HW-1:0] ux_ext;
    logic [2*HW-1:0] uz_ext;
    logic [2*HW-1:0] hh_x_reg, hl_x_reg, ll_x_reg;
    logic [2*HW-1:0] hh_z_reg, hl_z_reg, ll_z_reg;
    logic [RW-1:0]   sq_x_reg, sq_z_reg, sum_reg;

    assign ux_ext = (2*HW)'(ux);
    assign uz_ext = (2*HW)'(uz);

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_x_reg <= ux_ext[2*HW-1:HW] * ux_ext[2*HW-1:HW];
            hl_x_reg <= ux_ext[2*HW-1:HW] * ux_ext[HW-1:0];
            ll_x_reg <= ux_ext[HW-1:0]    * ux_ext[HW-1:0];
            hh_z_reg <= uz_ext[2*HW-1:HW] * uz_ext[2*HW-1:HW];
            hl_z_reg <= uz_ext[2*HW-1:HW] * uz_ext[HW-1:0];
            ll_z_reg <= uz_ext[HW-1:0]    * uz_ext[HW-1:0];
            sq_x_reg <= (RW'(hh_x_reg) << (2*HW)) + (RW'(hl_x_reg) << (HW+1)) + RW'(ll_x_reg);
            sq_z_reg <= (RW'(hh_z_reg) << (2*HW)) + (RW'(hl_z_reg) << (HW+1)) + RW'(ll_z_reg);
            sum_reg  <= sq_x_reg + sq_z_reg;
        end
    end

    logic [RW-1:0]    rad_in  [0:RB];
    logic [REM_W-1:0] rem_in  [0:RB];
    logic [RB-1:0]    root_in [0:RB];

    assign rad_in[0]  = sum_reg;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;

    // The radicand shifts up two bits per stage so that the next pair is
    // always found at the top.
    for (genvar j = 0; j < RB; j++) begin : g_root
        logic [RW-1:0]    rad_reg;
        logic [REM_W-1:0] rem_reg;
        logic [RB-1:0]    root_reg;
        logic [REM_W-1:0] rem_cat;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [RB-1:0]    root_next;

        always_comb begin
            rem_cat = {rem_in[j][REM_W-3:0], rad_in[j][RW-1 -: 2]};
            trial   = {root_in[j], 2'b01};
            if (rem_cat >= trial) begin
                rem_next  = rem_cat - trial;
                root_next = {root_in[j][RB-2:0], 1'b1};
            end else begin
                rem_next  = rem_cat;
                root_next = {root_in[j][RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg  <= rad_in[j] << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
        end

        assign rad_in[j+1]  = rad_reg;
        assign rem_in[j+1]  = rem_reg;
        assign root_in[j+1] = root_reg;
    end

    assign root = root_in[RB];

endmodule

@@ rtl/core/c2c_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2c_cordic
// Vectoring CORDIC, one iteration per stage, followed by clamping, quadrant
// folding, scaling to output units and the sign of the angle.
// ----------------------------------------------------------------------------
module c2c_cordic import c2c_pkg::*; #(
    parameter int COORD_WIDTH = 31,
    parameter int ANGLE_SCALE = 1000000
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [COORD_WIDTH-1:0] ux,
    input  logic [COORD_WIDTH-1:0] uz,
    input  c2c_flags_t             in_flags,
    output logic                   out_valid,
    output logic [ANGLE_W-1:0]     angle
);

    localparam int SH      = 59 - COORD_WIDTH;
    localparam int SCALE_W = $clog2(ANGLE_SCALE + 1);
    localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(ANGLE_SCALE);

    logic signed [63:0] x_in [0:ITERS];
    logic signed [63:0] y_in [0:ITERS];
    logic signed [63:0] z_in [0:ITERS];
    logic               v_in [0:ITERS];
    c2c_flags_t         f_in [0:ITERS];

    assign x_in[0] = $signed(64'(ux) << SH);
    assign y_in[0] = $signed(64'(uz) << SH);
    assign z_in[0] = '0;
    assign v_in[0] = in_valid;
    assign f_in[0] = in_flags;

    for (genvar i = 0; i < ITERS; i++) begin : g_iter
        localparam logic signed [63:0] ATAN_I = 64'(c2c_atan_q60(i));
        logic signed [63:0] xs, ys, x_next, y_next, z_next;
        logic signed [63:0] x_reg, y_reg, z_reg;
        logic               v_reg;
        c2c_flags_t         f_reg;

        always_comb begin
            xs = x_in[i] >>> i;
            ys = y_in[i] >>> i;
            if (y_in[i] > 0) begin
                x_next = x_in[i] + ys;
                y_next = y_in[i] - xs;
                z_next = z_in[i] + ATAN_I;
            end else begin
                x_next = x_in[i] - ys;
                y_next = y_in[i] + xs;
                z_next = z_in[i] - ATAN_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_in[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                f_reg <= f_in[i];
            end
        end

        assign x_in[i+1] = x_reg;
        assign y_in[i+1] = y_reg;
        assign z_in[i+1] = z_reg;
        assign v_in[i+1] = v_reg;
        assign f_in[i+1] = f_reg;
    end

    logic                       p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic                       p4_valid_reg, p5_valid_reg;
    c2c_flags_t                 p1_flags_reg, p2_flags_reg, p3_flags_reg, p4_flags_reg;
    logic [61:0]                zc_next, p1_zc_reg;
    logic [61:0]                mag_next, p2_mag_reg;
    logic [30+SCALE_W-1:0]      p3_prod_h_reg;
    logic [32+SCALE_W-1:0]      p3_prod_l_reg;
    logic [63:0]                hi;
    logic [ANGLE_W-1:0]         p4_ang_reg, p5_ang_reg;

    // Clamp the accumulated angle into the first quadrant.
    always_comb begin
        if (z_in[ITERS] < 0) begin
            zc_next = '0;
        end else if (z_in[ITERS] > HALF_PI_Q60) begin
            zc_next = 62'(HALF_PI_Q60);
        end else begin
            zc_next = z_in[ITERS][61:0];
        end
    end

    // Points on an axis bypass the iteration result; the left half plane
    // is folded about pi.
    always_comb begin
        if (p1_flags_reg.uz_zero) begin
            mag_next = p1_flags_reg.dx_neg ? 62'(PI_Q60) : '0;
        end else if (p1_flags_reg.ux_zero) begin
            mag_next = 62'(HALF_PI_Q60);
        end else if (p1_flags_reg.dx_neg) begin
            mag_next = 62'(PI_Q60) - p1_zc_reg;
        end else begin
            mag_next = p1_zc_reg;
        end
    end

    assign hi = 64'(p3_prod_h_reg) + 64'(p3_prod_l_reg >> 32);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= v_in[ITERS];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_flags_reg  <= f_in[ITERS];
            p1_zc_reg     <= zc_next;
            p2_flags_reg  <= p1_flags_reg;
            p2_mag_reg    <= mag_next;
            p3_flags_reg  <= p2_flags_reg;
            p3_prod_h_reg <= (30+SCALE_W)'(p2_mag_reg[61:32]) * (30+SCALE_W)'(SCALE);
            p3_prod_l_reg <= (32+SCALE_W)'(p2_mag_reg[31:0]) * (32+SCALE_W)'(SCALE);
            p4_flags_reg  <= p3_flags_reg;
            p4_ang_reg    <= hi[28 +: ANGLE_W];
            p5_ang_reg    <= p4_flags_reg.dz_neg ? ANGLE_W'(0) - p4_ang_reg : p4_ang_reg;
        end
    end

    assign out_valid = p5_valid_reg;
    assign angle     = p5_ang_reg;

endmodule

@@ rtl/core/cartesian_to_cylindrical.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_cylindrical
// Converts a 3D point to cylinder coordinates about a configurable axis
// parallel to y: CORDIC angle, integer square root radius, height pass-through.
// ----------------------------------------------------------------------------
// The path from the accepting edge to m_tvalid runs through the 60 CORDIC
// iteration stages plus two front stages, five angle finishing stages and the
// output register. Throughput: one point per cycle; s_tready falls only while
// the skid register holds a beat behind a stalled output.
// Reset (aresetn low, synchronous) empties the pipeline and clears both axis
// registers to zero.
module cartesian_to_cylindrical import c2c_pkg::*; #(
    parameter int COORD_WIDTH = 31,
    parameter int ANGLE_SCALE = 1000000
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_x, point_y, point_z from bit 0 up, zero padded to whole bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // angle, height, radius from bit 0 up, zero padded to whole bytes
    output logic [((COORD_WIDTH+ANGLE_W+RADIUS_W+7)/8)*8-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    localparam int OUT_W      = ((COORD_WIDTH + ANGLE_W + RADIUS_W + 7) / 8) * 8;
    localparam int OUT_BITS   = ANGLE_W + COORD_WIDTH + RADIUS_W;
    localparam int RB         = COORD_WIDTH + 1;
    localparam int CORDIC_LAT = ITERS + 5;
    localparam int RAD_DELAY  = CORDIC_LAT - (RB + 3);

    logic [COORD_WIDTH-1:0] axis_x_reg, axis_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_x_reg <= '0;
            axis_z_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_AXIS_X) begin
                axis_x_reg <= cfg_data;
            end else if (cfg_index == REG_AXIS_Z) begin
                axis_z_reg <= cfg_data;
            end
        end
    end

    logic pipe_en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    // Front stage one: offsets from the axis, one bit wider than a coordinate.
    logic [COORD_WIDTH-1:0] px, py, pz;
    logic [COORD_WIDTH:0]   dx_reg, dz_reg;
    logic [COORD_WIDTH-1:0] py1_reg, py2_reg;
    logic                   f1_valid_reg, f2_valid_reg;

    assign px = s_tdata[0 +: COORD_WIDTH];
    assign py = s_tdata[COORD_WIDTH +: COORD_WIDTH];
    assign pz = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];

    // Front stage two: magnitudes and the quadrant flags.
    logic [COORD_WIDTH:0]   ndx, ndz;
    logic [COORD_WIDTH-1:0] ux_reg, uz_reg;
    c2c_flags_t             flags_next, flags_reg;

    assign ndx = -dx_reg;
    assign ndz = -dz_reg;

    always_comb begin
        flags_next.dx_neg  = dx_reg[COORD_WIDTH];
        flags_next.dz_neg  = dz_reg[COORD_WIDTH];
        flags_next.ux_zero = (dx_reg == '0);
        flags_next.uz_zero = (dz_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            f1_valid_reg <= s_tvalid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dx_reg    <= {px[COORD_WIDTH-1], px} - {axis_x_reg[COORD_WIDTH-1], axis_x_reg};
            dz_reg    <= {pz[COORD_WIDTH-1], pz} - {axis_z_reg[COORD_WIDTH-1], axis_z_reg};
            py1_reg   <= py;
            ux_reg    <= dx_reg[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : dx_reg[COORD_WIDTH-1:0];
            uz_reg    <= dz_reg[COORD_WIDTH] ? ndz[COORD_WIDTH-1:0] : dz_reg[COORD_WIDTH-1:0];
            flags_reg <= flags_next;
            py2_reg   <= py1_reg;
        end
    end

    logic                   ang_valid;
    logic [ANGLE_W-1:0]     angle;
    logic [COORD_WIDTH:0]   root, root_d;
    logic [COORD_WIDTH-1:0] height_d;
    logic [RB+RADIUS_W-1:0] root_ext;
    logic [RADIUS_W-1:0]    radius;
    logic [OUT_BITS-1:0]    pipe_data;

    c2c_cordic #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_SCALE (ANGLE_SCALE)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (f2_valid_reg),
        .ux        (ux_reg),
        .uz        (uz_reg),
        .in_flags  (flags_reg),
        .out_valid (ang_valid),
        .angle     (angle)
    );

    c2c_isqrt #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_isqrt (
        .aclk (aclk),
        .en   (pipe_en),
        .ux   (ux_reg),
        .uz   (uz_reg),
        .root (root)
    );

    c2c_delay #(
        .WIDTH (RB),
        .DEPTH (RAD_DELAY)
    ) u_radius_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .din  (root),
        .dout (root_d)
    );

    c2c_delay #(
        .WIDTH (COORD_WIDTH),
        .DEPTH (CORDIC_LAT)
    ) u_height_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .din  (py2_reg),
        .dout (height_d)
    );

    assign root_ext  = (RB+RADIUS_W)'(root_d);
    assign radius    = root_ext[RADIUS_W-1:0];
    assign pipe_data = {radius, height_d, angle};

    // Output register with a skid register behind it. The pipeline halts
    // only once the skid register is occupied.
    logic [OUT_BITS-1:0] out_data_reg, skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= ang_valid;
            out_data_reg  <= pipe_data;
        end else if (ang_valid) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= pipe_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_stall_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && ang_valid && pipe_en) |=> skid_valid_reg)
        else $error("beat leaving the pipeline at a stalled output was not caught");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid register did not drain into the output register");

    a_cfg_axis_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == REG_AXIS_X) |=> (axis_x_reg == $past(cfg_data)))
        else $error("axis x write was not taken");

endmodule
